// ===== sv/ped_pkg.sv =====
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and constants of the pairwise Euclidean distance block.
// ----------------------------------------------------------------------------
package ped_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int RCNT_W      = ROW_W + 1;
	localparam int MAX_COLS    = 1024;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int CCNT_W      = COL_W + 1;
	localparam int SAMPLE_BITS = 16;
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int SUM_W       = SQ_W + COL_W;
	localparam int DIST_W      = (SUM_W + 1) / 2;
	localparam int REM_W       = DIST_W + 4;
	localparam int ITER_W      = $clog2(DIST_W + 1);
	localparam int CFG_W       = 11;
	localparam int PADDR_W     = 3;

	localparam logic [PADDR_W-1:0] REG_COL_COUNT = '0;

	typedef struct packed {
		logic signed [15:0] value;
		logic               new_set;
	} sample_t;

	typedef struct packed {
		logic [5:0]  this_row;
		logic [5:0]  other_row;
		logic [20:0] distance;
		logic        store_full;
		logic        last;
	} result_t;

	typedef struct packed {
		logic             load;
		logic             st_rd;
		logic             st_wr;
		logic             sum_rd;
		logic             sum_wr;
		logic             diff_en;
		logic             sq_en;
		logic             sqrt_ld;
		logic             first_col;
		logic [ROW_W-1:0] rd_row;
		logic [ROW_W-1:0] wr_row;
		logic [COL_W-1:0] col;
	} dp_cmd_t;

	typedef struct packed {
		logic sqrt_done;
	} dp_stat_t;

endpackage

// ===== sv/ped_datapath.sv =====
// ----------------------------------------------------------------------------
// ped_datapath
// Sample store, per-row running sums, subtract-square-accumulate unit and a
// bit-serial integer square root.
// ----------------------------------------------------------------------------
module ped_datapath import ped_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic signed [15:0]   value,
	output dp_stat_t             stat,
	output logic [DIST_W-1:0]    root
);

	logic signed [SAMPLE_BITS-1:0] st_mem [MAX_ROWS*MAX_COLS];
	logic [SUM_W-1:0]              sum_mem [MAX_ROWS];

	logic signed [SAMPLE_BITS-1:0] v_q;
	logic signed [SAMPLE_BITS-1:0] st_rd_q;
	logic [SUM_W-1:0]              sum_rd_q;
	logic [SAMPLE_BITS-1:0]        ad_q;
	logic [SQ_W-1:0]               sq_q;
	logic [SUM_W-1:0]              n_q;
	logic [REM_W-1:0]              rem_q;
	logic [DIST_W-1:0]             root_q;
	logic [ITER_W-1:0]             iter_q;

	logic signed [SAMPLE_BITS:0]   diff;
	logic [SAMPLE_BITS:0]          adiff;
	logic [SUM_W-1:0]              acc;
	logic [REM_W-1:0]              rem_n;
	logic [REM_W-1:0]              trial;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= value[SAMPLE_BITS-1:0];
		end
		if (cmd.st_wr) begin
			st_mem[{cmd.wr_row, cmd.col}] <= v_q;
		end
		if (cmd.st_rd) begin
			st_rd_q <= st_mem[{cmd.rd_row, cmd.col}];
		end
		if (cmd.sum_wr) begin
			sum_mem[cmd.rd_row] <= acc;
		end
		if (cmd.sum_rd) begin
			sum_rd_q <= sum_mem[cmd.rd_row];
		end
	end

	assign diff  = {v_q[SAMPLE_BITS-1], v_q} - {st_rd_q[SAMPLE_BITS-1], st_rd_q};
	assign adiff = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(0) - diff : diff;
	assign acc   = cmd.first_col ? SUM_W'(sq_q) : sum_rd_q + SUM_W'(sq_q);

	always_ff @(posedge clk) begin
		if (cmd.diff_en) begin
			ad_q <= adiff[SAMPLE_BITS-1:0];
		end
		if (cmd.sq_en) begin
			sq_q <= SQ_W'(ad_q) * SQ_W'(ad_q);
		end
	end

	// one result bit per cycle: bring down two bits, try (root << 2) | 1
	assign rem_n = {rem_q[REM_W-3:0], n_q[SUM_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.sqrt_ld) begin
			iter_q <= ITER_W'(DIST_W);
		end else if (iter_q != '0) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_ld) begin
			n_q    <= sum_rd_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (iter_q != '0) begin
			n_q <= n_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[DIST_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[DIST_W-2:0], 1'b0};
			end
		end
	end

	assign stat.sqrt_done = (iter_q == '0);
	assign root           = root_q;

endmodule

// ===== sv/ped_ctrl.sv =====
// ----------------------------------------------------------------------------
// ped_ctrl
// Sequencer: row and column counters, compare loop over stored rows and the
// result loop at the end of each row.
// ----------------------------------------------------------------------------
module ped_ctrl import ped_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              new_set,
	input  logic [CFG_W-1:0]  col_count,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd,
	output logic              busy,
	output logic              emit,
	output logic              use_root,
	output logic [5:0]        this_row,
	output logic [5:0]        other_row,
	output logic              store_full,
	output logic              last
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_CMP_RD   = 11'b00000000010,
		S_CMP_DIFF = 11'b00000000100,
		S_CMP_SQ   = 11'b00000001000,
		S_CMP_ACC  = 11'b00000010000,
		S_STORE    = 11'b00000100000,
		S_OUT_RD   = 11'b00001000000,
		S_OUT_LD   = 11'b00010000000,
		S_OUT_SQRT = 11'b00100000000,
		S_OUT_EMIT = 11'b01000000000,
		S_SELF     = 11'b10000000000
	} state_t;

	localparam logic [RCNT_W-1:0] ROWS_FULL = RCNT_W'(MAX_ROWS);
	localparam logic [CCNT_W-1:0] COLS_MAX  = CCNT_W'(MAX_COLS);

	state_t            state_q;
	logic              full_q;
	logic [RCNT_W-1:0] rows_q;
	logic [RCNT_W-1:0] r_q;
	logic [COL_W-1:0]  cpos_q;
	logic [COL_W-1:0]  c_q;
	logic [ROW_W-1:0]  k_q;

	logic [CCNT_W-1:0] cols;
	logic [RCNT_W-1:0] r_n;
	logic [COL_W-1:0]  cpos_n;
	logic              accept;
	logic              row_end;
	logic              k_last;

	always_comb begin
		if (col_count == '0) begin
			cols = CCNT_W'(1);
		end else if (col_count > COLS_MAX) begin
			cols = COLS_MAX;
		end else begin
			cols = col_count;
		end
	end

	assign accept  = start && (state_q == S_IDLE);
	assign r_n     = new_set ? '0 : rows_q;
	assign cpos_n  = new_set ? '0 : cpos_q;
	assign row_end = (CCNT_W'(cpos_q) + 1'b1) >= cols;
	assign k_last  = (k_q == r_q[ROW_W-1:0] - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			full_q  <= 1'b0;
			rows_q  <= '0;
			r_q     <= '0;
			cpos_q  <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					full_q <= 1'b0;
					if (accept) begin
						rows_q <= r_n;
						r_q    <= r_n;
						cpos_q <= cpos_n;
						c_q    <= (CCNT_W'(cpos_n) >= cols) ? COL_W'(cols - 1'b1) : cpos_n;
						k_q    <= '0;
						if (r_n != '0 && r_n < ROWS_FULL) begin
							state_q <= S_CMP_RD;
						end else begin
							state_q <= S_STORE;
						end
					end
				end
				S_CMP_RD:   state_q <= S_CMP_DIFF;
				S_CMP_DIFF: state_q <= S_CMP_SQ;
				S_CMP_SQ:   state_q <= S_CMP_ACC;
				S_CMP_ACC: begin
					k_q <= k_q + 1'b1;
					state_q <= k_last ? S_STORE : S_CMP_RD;
				end
				S_STORE: begin
					k_q <= '0;
					if (row_end) begin
						cpos_q <= '0;
						if (r_q == ROWS_FULL) begin
							full_q  <= 1'b1;
							state_q <= S_SELF;
						end else if (r_q == '0) begin
							state_q <= S_SELF;
						end else begin
							state_q <= S_OUT_RD;
						end
					end else begin
						cpos_q  <= cpos_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_OUT_RD:   state_q <= S_OUT_LD;
				S_OUT_LD:   state_q <= S_OUT_SQRT;
				S_OUT_SQRT: begin
					if (stat.sqrt_done) begin
						state_q <= S_OUT_EMIT;
					end
				end
				S_OUT_EMIT: begin
					k_q <= k_q + 1'b1;
					state_q <= k_last ? S_SELF : S_OUT_RD;
				end
				S_SELF: begin
					if (!full_q) begin
						rows_q <= r_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.st_rd     = (state_q == S_CMP_RD);
		cmd.sum_rd    = (state_q == S_CMP_RD) || (state_q == S_OUT_RD);
		cmd.diff_en   = (state_q == S_CMP_DIFF);
		cmd.sq_en     = (state_q == S_CMP_SQ);
		cmd.sum_wr    = (state_q == S_CMP_ACC);
		cmd.st_wr     = (state_q == S_STORE) && (r_q != ROWS_FULL);
		cmd.sqrt_ld   = (state_q == S_OUT_LD);
		cmd.first_col = (cpos_q == '0);
		cmd.rd_row    = k_q;
		cmd.wr_row    = r_q[ROW_W-1:0];
		cmd.col       = c_q;
	end

	assign busy       = (state_q != S_IDLE);
	assign emit       = (state_q == S_OUT_EMIT) || (state_q == S_SELF);
	assign use_root   = (state_q == S_OUT_EMIT);
	assign this_row   = full_q ? 6'd0 : 6'(r_q[ROW_W-1:0]);
	assign other_row  = full_q ? 6'd0 : ((state_q == S_SELF) ? 6'(r_q[ROW_W-1:0]) : 6'(k_q));
	assign store_full = full_q;
	assign last       = (state_q == S_SELF);

endmodule

// ===== sv/pairwise_euclidean_distance.sv =====
// ----------------------------------------------------------------------------
// pairwise_euclidean_distance
// Lower triangle of the Euclidean distance matrix of a streamed data matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present sample and raise start; the transaction is taken on a
//   clock edge with start high and busy low. Elements arrive row by row,
//   col_count to a row; new_set = 1 discards all stored rows first.
//   Config: APB register col_count at address 0 (reset 1); the user must
//   write it only while busy is low, which the block does not enforce.
//   Output: each result is on result for one cycle with result_valid high.
//   The receiver cannot stall; it must take every result.
//   Sequence: an element of row r makes one pass of the shared
//   subtract-square-accumulate unit per stored row, with steps for memory
//   read, difference, square and sum write. The last element of a row then
//   gives one result per earlier row through the bit-serial square root
//   (21 iterations), then the self result marked last.
//   A row past the 64-row store gives one result with store_full = 1.
//   Reset: rows and column position clear, col_count returns to 1; the
//   sample memory is not cleared.
// ----------------------------------------------------------------------------
module pairwise_euclidean_distance import ped_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sample_t             sample,
	output logic                result_valid,
	output result_t             result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [CFG_W-1:0]  col_count_q;
	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [DIST_W-1:0] root;
	logic              use_root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= CFG_W'(1);
		end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_COL_COUNT[PADDR_W-1:2]) begin
			col_count_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_COL_COUNT[PADDR_W-1:2]) ?
		32'(col_count_q) : 32'd0;

	ped_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.new_set    (sample.new_set),
		.col_count  (col_count_q),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.emit       (result_valid),
		.use_root   (use_root),
		.this_row   (result.this_row),
		.other_row  (result.other_row),
		.store_full (result.store_full),
		.last       (result.last)
	);

	ped_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (sample.value),
		.stat   (stat),
		.root   (root)
	);

	assign result.distance = use_root ? 21'(root) : 21'd0;

endmodule
